@@ hdl/bdp_pkg.sv @@
// Shared types, constants and the f32 adder for the bf16 dot-product block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bdp_pkg;

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX  = 8'hFF;

    // Control that travels with a word down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } bdp_ctl_t;

    // IEEE f32 add, round to nearest even. Any NaN gives the quiet NaN.
    // With ftz set, a denormal result becomes zero of the same sign.
    function automatic logic [31:0] fp32_add(input logic [31:0] a,
                                             input logic [31:0] b,
                                             input logic ftz);
        logic        a_nan;
        logic        b_nan;
        logic        a_inf;
        logic        b_inf;
        logic        swap;
        logic [31:0] x;
        logic [31:0] y;
        logic        sx;
        logic        sy;
        logic [8:0]  xe;
        logic [8:0]  ye;
        logic [23:0] xm;
        logic [23:0] ym;
        logic [26:0] yw;
        logic [26:0] ysh;
        logic [26:0] mask;
        logic [8:0]  d;
        logic        sub;
        logic [27:0] s;
        logic [27:0] n;
        logic [4:0]  lz;
        logic [4:0]  sh;
        logic [8:0]  e;
        logic [8:0]  ef;
        logic        up;
        logic [24:0] r;
        logic [22:0] frac;
        logic [31:0] res;
        a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        swap  = (a[30:0] < b[30:0]);
        x     = swap ? b : a;
        y     = swap ? a : b;
        sx    = x[31];
        sy    = y[31];
        xe    = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
        ye    = (y[30:23] == 8'd0) ? 9'd1 : {1'b0, y[30:23]};
        xm    = {x[30:23] != 8'd0, x[22:0]};
        ym    = {y[30:23] != 8'd0, y[22:0]};
        yw    = {ym, 3'b000};
        d     = xe - ye;
        if (d >= 9'd27) begin
            ysh = {26'd0, |yw};
        end
        else begin
            mask   = ~({27{1'b1}} << d[4:0]);
            ysh    = yw >> d[4:0];
            ysh[0] = ysh[0] | (|(yw & mask));
        end
        sub = sx ^ sy;
        if (sub) begin
            s = {1'b0, xm, 3'b000} - {1'b0, ysh};
        end
        else begin
            s = {1'b0, xm, 3'b000} + {1'b0, ysh};
        end
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (s[i]) begin
                lz = 5'(26 - i);
            end
        end
        if (s[27]) begin
            n    = {1'b0, s[27:1]};
            n[0] = n[0] | s[0];
            e    = xe + 9'd1;
        end
        else begin
            // Normalize, but stop at the smallest exponent so the value stays denormal.
            if ({4'd0, lz} <= (xe - 9'd1)) begin
                sh = lz;
            end
            else begin
                sh = 5'(xe - 9'd1);
            end
            n = s << sh;
            e = xe - {4'd0, sh};
        end
        up   = n[2] & (n[1] | n[0] | n[3]);
        r    = {1'b0, n[26:3]} + {24'd0, up};
        ef   = r[24] ? (e + 9'd1) : (r[23] ? e : 9'd0);
        frac = r[24] ? r[23:1] : r[22:0];
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            res = F32_QNAN;
        end
        else if (a_inf) begin
            res = a;
        end
        else if (b_inf) begin
            res = b;
        end
        else if (s == 28'd0) begin
            res = {sub ? 1'b0 : sx, 31'd0};
        end
        else if (ef >= 9'd255) begin
            res = {sx, EXP_MAX, 23'd0};
        end
        else if (ftz && (ef == 9'd0)) begin
            res = {sx, 31'd0};
        end
        else begin
            res = {sx, ef[7:0], frac};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bdp_mul.sv @@
// Product stage: bf16 times bf16 into an exact f32 with denormals flushed.
// Depends on bdp_pkg for the control struct and NaN constant.
`default_nettype none

module bdp_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire bdp_pkg::bdp_ctl_t ctl_in,
    input  wire logic [15:0]       weight,
    input  wire logic [15:0]       activation,
    input  wire logic [15:0]       bias_in,
    output bdp_pkg::bdp_ctl_t      ctl_out,
    output logic [31:0]            prod,
    output logic [15:0]            bias_out
);
    import bdp_pkg::*;

    bdp_ctl_t    ctl_reg;
    logic [31:0] prod_reg;
    logic [15:0] bias_reg;
    logic [31:0] prod_next;

    logic        w_zero;
    logic        x_zero;
    logic        w_inf;
    logic        x_inf;
    logic        w_nan;
    logic        x_nan;
    logic        psign;
    logic [15:0] pm;
    logic [9:0]  pe;

    always_comb
    begin
        w_zero = (weight[14:7] == 8'd0);
        x_zero = (activation[14:7] == 8'd0);
        w_inf  = (weight[14:7] == EXP_MAX) && (weight[6:0] == 7'd0);
        x_inf  = (activation[14:7] == EXP_MAX) && (activation[6:0] == 7'd0);
        w_nan  = (weight[14:7] == EXP_MAX) && (weight[6:0] != 7'd0);
        x_nan  = (activation[14:7] == EXP_MAX) && (activation[6:0] != 7'd0);
        psign  = weight[15] ^ activation[15];
        pm     = {1'b1, weight[6:0]} * {1'b1, activation[6:0]};
        // The 16-bit product fits the f32 mantissa, so only range limits matter.
        pe     = {2'b00, weight[14:7]} + {2'b00, activation[14:7]} + {9'd0, pm[15]}
                 - 10'd127;
        if (w_nan || x_nan || ((w_inf || x_inf) && (w_zero || x_zero))) begin
            prod_next = F32_QNAN;
        end
        else if (w_inf || x_inf) begin
            prod_next = {psign, EXP_MAX, 23'd0};
        end
        else if (w_zero || x_zero || pe[9] || (pe == 10'd0)) begin
            prod_next = {psign, 31'd0};
        end
        else if (pe >= 10'd255) begin
            prod_next = {psign, EXP_MAX, 23'd0};
        end
        else if (pm[15]) begin
            prod_next = {psign, pe[7:0], pm[14:0], 8'd0};
        end
        else begin
            prod_next = {psign, pe[7:0], pm[13:0], 9'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end
        else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            prod_reg <= prod_next;
            bias_reg <= bias_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign prod     = prod_reg;
    assign bias_out = bias_reg;

endmodule

`default_nettype wire

@@ hdl/bdp_acc.sv @@
// Accumulator stage: one flushed f32 add per word, row sum flagged valid on last.
// Depends on bdp_pkg for fp32_add and the control struct.
`default_nettype none

module bdp_acc (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire bdp_pkg::bdp_ctl_t ctl_in,
    input  wire logic [31:0]       prod,
    input  wire logic [15:0]       bias_in,
    output logic                   row_valid,
    output logic [31:0]            row_sum,
    output logic [15:0]            bias_out
);
    import bdp_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        row_valid_reg;
    logic [31:0] row_sum_reg;
    logic [15:0] bias_reg;
    logic [31:0] sum;

    assign sum      = fp32_add(acc_reg, prod, 1'b1);
    assign acc_next = ctl_in.last ? 32'd0 : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg       <= 32'd0;
            row_valid_reg <= 1'b0;
        end
        else if (en) begin
            if (ctl_in.valid) begin
                acc_reg <= acc_next;
            end
            row_valid_reg <= ctl_in.valid & ctl_in.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            row_sum_reg <= sum;
            bias_reg    <= bias_in;
        end
    end

    assign row_valid = row_valid_reg;
    assign row_sum   = row_sum_reg;
    assign bias_out  = bias_reg;

endmodule

`default_nettype wire

@@ hdl/bdp_round.sv @@
// Output stage: optional bias add in full IEEE f32, then rounding to bf16.
// Depends on bdp_pkg for fp32_add and the NaN constant.
`default_nettype none

module bdp_round (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        bias_enable,
    input  wire logic        row_valid,
    input  wire logic [31:0] row_sum,
    input  wire logic [15:0] bias,
    output logic             sum_valid,
    output logic [15:0]      sum_out
);
    import bdp_pkg::*;

    logic        sum_valid_reg;
    logic [15:0] sum_out_reg;
    logic [31:0] bias_f;
    logic [31:0] total;
    logic [31:0] rounded;
    logic [15:0] sum_out_next;

    assign bias_f  = bias_enable ? {bias, 16'd0} : 32'd0;
    assign total   = fp32_add(row_sum, bias_f, 1'b0);
    assign rounded = total + 32'h0000_7FFF + {31'd0, total[16]};

    always_comb
    begin
        if (total == F32_QNAN) begin
            sum_out_next = F32_QNAN[31:16];
        end
        else begin
            sum_out_next = rounded[31:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_valid_reg <= 1'b0;
        end
        else if (en) begin
            sum_valid_reg <= row_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            sum_out_reg <= sum_out_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_out   = sum_out_reg;

endmodule

`default_nettype wire

@@ hdl/bf16_dot_product_bias_top.sv @@
// bf16 dot product with f32 accumulation and optional bias: top level.
// Depends on bdp_pkg, bdp_mul, bdp_acc and bdp_round.
//
// The block takes one word (weight, activation, row bias, last) per clock
// and produces one bf16 result word per row once the last word clears the
// input, product, accumulator and output stages. The rate of one word per
// cycle is set by the accumulator, whose combinational f32 add is the
// only feedback loop. The whole pipeline halts while a result waits under
// sum_stall. bias_enable is written through the always-ready cfg port.
`default_nettype none

module bf16_dot_product_bias_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [15:0] weight,
    input  wire logic [15:0] activation,
    input  wire logic [15:0] row_bias,
    input  wire logic        last,
    output logic             sum_valid,
    input  wire logic        sum_stall,
    output logic [15:0]      sum_out
);
    import bdp_pkg::*;

    logic        bias_enable_reg;
    logic        en;
    bdp_ctl_t    in_ctl_reg;
    bdp_ctl_t    in_ctl_next;
    logic [15:0] weight_reg;
    logic [15:0] activation_reg;
    logic [15:0] bias_reg;
    bdp_ctl_t    mul_ctl;
    logic [31:0] prod;
    logic [15:0] mul_bias;
    logic        row_valid;
    logic [31:0] row_sum;
    logic [15:0] acc_bias;

    // The pipeline moves unless a finished word is held at the output.
    assign en         = ~(sum_valid & sum_stall);
    assign item_stall = ~en;
    assign cfg_ready  = 1'b1;

    assign in_ctl_next.valid = item_valid;
    assign in_ctl_next.last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bias_enable_reg <= 1'b0;
            in_ctl_reg      <= '0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                bias_enable_reg <= cfg_data;
            end
            if (en) begin
                in_ctl_reg <= in_ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            weight_reg     <= weight;
            activation_reg <= activation;
            bias_reg       <= row_bias;
        end
    end

    bdp_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (in_ctl_reg),
        .weight     (weight_reg),
        .activation (activation_reg),
        .bias_in    (bias_reg),
        .ctl_out    (mul_ctl),
        .prod       (prod),
        .bias_out   (mul_bias)
    );

    bdp_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (mul_ctl),
        .prod      (prod),
        .bias_in   (mul_bias),
        .row_valid (row_valid),
        .row_sum   (row_sum),
        .bias_out  (acc_bias)
    );

    bdp_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .bias_enable (bias_enable_reg),
        .row_valid   (row_valid),
        .row_sum     (row_sum),
        .bias        (acc_bias),
        .sum_valid   (sum_valid),
        .sum_out     (sum_out)
    );

endmodule

`default_nettype wire
